// File: hw/rtl/dble_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dble_pkg
// shared types and constants of the degree bucket list engine
// ----------------------------------------------------------------------------
package dble_pkg;

    localparam int unsigned COL_W = 10;

    typedef logic [COL_W-1:0] col_t;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_UNLINK = 2'd1,
        CMD_HEAD   = 2'd2,
        CMD_LINKS  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR2
    } state_t;

    // one write into a column-wide store
    typedef struct packed {
        logic en;
        col_t addr;
        col_t data;
    } col_wr_t;

endpackage

// File: hw/rtl/dble_head_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dble_head_store
// bucket head memory with a clearing sweep after reset
// ----------------------------------------------------------------------------
module dble_head_store #(
    parameter int unsigned NUM_BUCKETS = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  dble_pkg::col_t   rd_degree,
    input  dble_pkg::col_wr_t wr,
    output dble_pkg::col_t   rd_data,
    output logic             busy
);
    import dble_pkg::*;

    localparam int unsigned BAW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    col_t           head_mem [0:NUM_BUCKETS-1];
    logic           clr_reg;
    logic           clr_next;
    logic [BAW-1:0] clr_addr_reg;
    logic [BAW-1:0] clr_addr_next;

    logic [BAW+COL_W-1:0] rd_ext;
    logic [BAW+COL_W-1:0] wr_ext;
    logic [BAW-1:0]       rd_addr;
    logic [BAW-1:0]       wr_addr;
    logic                 we;
    logic [BAW-1:0]       we_addr;
    col_t                 we_data;

    assign rd_ext  = {{BAW{1'b0}}, rd_degree};
    assign wr_ext  = {{BAW{1'b0}}, wr.addr};
    assign rd_addr = rd_ext[BAW-1:0];
    assign wr_addr = wr_ext[BAW-1:0];
    assign busy    = clr_reg;

    always_comb begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (32'(clr_addr_reg) == NUM_BUCKETS - 1) begin
                clr_next = 1'b0;
            end
        end
    end

    // sweep writes zero, one bucket a cycle; otherwise the port write passes
    always_comb begin
        if (clr_reg) begin
            we      = 1'b1;
            we_addr = clr_addr_reg;
            we_data = '0;
        end else begin
            we      = wr.en;
            we_addr = wr_addr;
            we_data = wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            head_mem[we_addr] <= we_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= head_mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/degree_bucket_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degree_bucket_list_engine_top
// doubly linked column lists, one per degree bucket
// ----------------------------------------------------------------------------
// Usage: each item on the s_ channel is a command (push, unlink, read head,
// read links) with a column and a degree. Every item gives exactly one result
// on the m_ channel: the bucket head, successor and predecessor of the
// addressed column after the command. Column 0 means none.
// Timing: the item is taken in idle and the head and link memories are read
// as it is taken; the read-modify-write happens in ST_RD once the output
// register is free. A push into a non-empty bucket adds ST_WR2, where the
// second write into the predecessor memory is done. The result is registered
// and is offered once ST_RD has loaded the output register.
// Reset: after aresetn the head memory is swept to zero, one bucket a cycle,
// over all NUM_BUCKETS buckets, while s_ready stays low. Link memories are not cleared.
// Stall: a result waits in the output register; the next item is still
// taken, but its result is held back until m_ready frees the register.
// ----------------------------------------------------------------------------
module degree_bucket_list_engine_top #(
    parameter int unsigned NUM_COLUMNS = 1023,
    parameter int unsigned NUM_BUCKETS = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dble_pkg::cmd_t s_cmd,
    input  dble_pkg::col_t s_column,
    input  dble_pkg::col_t s_degree,
    output logic           m_valid,
    input  logic           m_ready,
    output dble_pkg::col_t m_bucket_head,
    output dble_pkg::col_t m_next_column,
    output dble_pkg::col_t m_prev_column
);
    import dble_pkg::*;

    localparam int unsigned LINK_DEPTH = NUM_COLUMNS + 1;
    localparam int unsigned CAW        = $clog2(LINK_DEPTH);

    function automatic logic col_ok(input col_t c);
        return (c != '0) && (32'(c) <= NUM_COLUMNS);
    endfunction

    function automatic logic [CAW-1:0] caddr(input col_t c);
        logic [CAW+COL_W-1:0] ext;
        ext = {{CAW{1'b0}}, c};
        return ext[CAW-1:0];
    endfunction

    col_t next_mem [0:LINK_DEPTH-1];
    col_t prev_mem [0:LINK_DEPTH-1];

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    col_t   col_reg;
    col_t   deg_reg;
    col_t   n_q;
    col_t   p_q;
    col_t   h_q;
    logic   clearing;
    logic   accept;

    logic   m_valid_reg, m_valid_next;
    logic   out_load;
    col_t   res_head, res_next, res_prev;
    col_t   bucket_head_reg, next_column_reg, prev_column_reg;

    col_wr_t head_wr, next_wr, prev_wr;

    logic cv, dv, do_push, do_unl, out_free;

    assign s_ready = (state_reg == ST_IDLE) && !clearing;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_bucket_head = bucket_head_reg;
    assign m_next_column = next_column_reg;
    assign m_prev_column = prev_column_reg;

    dble_head_store #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_heads (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_degree (s_degree),
        .wr        (head_wr),
        .rd_data   (h_q),
        .busy      (clearing)
    );

    assign cv       = col_ok(col_reg);
    assign dv       = 32'(deg_reg) < NUM_BUCKETS;
    assign do_push  = cv && dv && (cmd_reg == CMD_PUSH);
    assign do_unl   = cv && dv && (cmd_reg == CMD_UNLINK);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        head_wr    = '0;
        next_wr    = '0;
        prev_wr    = '0;
        res_head   = h_q;
        res_next   = n_q;
        res_prev   = p_q;

        if (do_push) begin
            res_head = col_reg;
            res_next = h_q;
            res_prev = (col_ok(h_q) && h_q == col_reg) ? col_reg : '0;
        end else if (do_unl) begin
            res_head = (p_q == '0) ? n_q : h_q;
            if (p_q != '0 && col_ok(p_q) && p_q == col_reg) begin
                res_next = n_q;
            end
            if (col_ok(n_q) && n_q == col_reg) begin
                res_prev = p_q;
            end
        end
        if (!dv) begin
            res_head = '0;
        end
        if (!cv) begin
            res_next = '0;
            res_prev = '0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                // hold until the previous result has left
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (do_push) begin
                        head_wr = '{en: 1'b1, addr: deg_reg, data: col_reg};
                        next_wr = '{en: 1'b1, addr: col_reg, data: h_q};
                        prev_wr = '{en: 1'b1, addr: col_reg, data: '0};
                        if (col_ok(h_q)) begin
                            state_next = ST_WR2;
                        end
                    end else if (do_unl) begin
                        if (p_q == '0) begin
                            head_wr = '{en: 1'b1, addr: deg_reg, data: n_q};
                        end else if (col_ok(p_q)) begin
                            next_wr = '{en: 1'b1, addr: p_q, data: n_q};
                        end
                        if (col_ok(n_q)) begin
                            prev_wr = '{en: 1'b1, addr: n_q, data: p_q};
                        end
                    end
                end
            end
            ST_WR2: begin
                // old head now points back at the pushed column
                prev_wr    = '{en: 1'b1, addr: h_q, data: col_reg};
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_cmd;
            col_reg <= s_column;
            deg_reg <= s_degree;
        end
        if (out_load) begin
            bucket_head_reg <= res_head;
            next_column_reg <= res_next;
            prev_column_reg <= res_prev;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            n_q <= next_mem[caddr(s_column)];
            p_q <= prev_mem[caddr(s_column)];
        end
    end

    always_ff @(posedge aclk) begin
        if (next_wr.en) begin
            next_mem[caddr(next_wr.addr)] <= next_wr.data;
        end
        if (prev_wr.en) begin
            prev_mem[caddr(prev_wr.addr)] <= prev_wr.data;
        end
    end

endmodule

// File: verif/degree_bucket_list_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degree_bucket_list_engine_top_tb
// self-checking bench for the degree bucket list engine: a short directed
// table, then random push, unlink, query, walk and broken sequences; each
// result checked against its typed row or a model of head and link stores
// ----------------------------------------------------------------------------
module degree_bucket_list_engine_top_tb;

    import dble_pkg::*;

    localparam int unsigned NUM_COLUMNS = 1023;
    localparam int unsigned NUM_BUCKETS = 1024;
    localparam int          RANDOM_ITEMS = 1850;
    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          WALK_MAX = 24;

    typedef struct packed {
        col_t head;
        col_t nxt;
        col_t prv;
    } column_view_t;

    typedef struct {
        cmd_t         cmd;
        col_t         column;
        col_t         degree;
        bit           typed;
        column_view_t view;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cmd_t s_cmd = CMD_PUSH;
    col_t s_column = '0;
    col_t s_degree = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    col_t m_bucket_head;
    col_t m_next_column;
    col_t m_prev_column;

    // model of the engine's stores
    col_t head_mem [NUM_BUCKETS];
    col_t next_mem [NUM_COLUMNS+1];
    col_t prev_mem [NUM_COLUMNS+1];

    column_view_t expected_views[$];
    col_t         known_cols[$];
    col_t         listed_cols[$];
    bit           col_known [NUM_COLUMNS+1];
    int           member_deg [NUM_COLUMNS+1];

    int items_sent = 0;
    int total_items;
    int src_gap_pct = 13;
    int snk_gap_pct = 54;
    int fail_count = 0;
    int idle_cycles = 0;

    stim_row_t directed_rows [20] = '{
        '{CMD_HEAD,   10'd0,    10'd0,    1'b1, '{10'd0,    10'd0,    10'd0}},
        '{CMD_HEAD,   10'd0,    10'd1023, 1'b1, '{10'd0,    10'd0,    10'd0}},
        '{CMD_PUSH,   10'd1023, 10'd1023, 1'b1, '{10'd1023, 10'd0,    10'd0}},
        '{CMD_PUSH,   10'd1,    10'd1023, 1'b1, '{10'd1,    10'd1023, 10'd0}},
        '{CMD_LINKS,  10'd1023, 10'd1023, 1'b1, '{10'd1,    10'd0,    10'd1}},
        '{CMD_PUSH,   10'd0,    10'd5,    1'b1, '{10'd0,    10'd0,    10'd0}},
        '{CMD_UNLINK, 10'd0,    10'd1023, 1'b1, '{10'd1,    10'd0,    10'd0}},
        '{CMD_PUSH,   10'd512,  10'd0,    1'b1, '{10'd512,  10'd0,    10'd0}},
        '{CMD_PUSH,   10'd341,  10'd0,    0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_PUSH,   10'd682,  10'd0,    0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_UNLINK, 10'd341,  10'd0,    0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_LINKS,  10'd682,  10'd0,    0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_UNLINK, 10'd682,  10'd0,    0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_UNLINK, 10'd512,  10'd0,    1'b1, '{10'd0,    10'd0,    10'd0}},
        '{CMD_HEAD,   10'd1,    10'd1023, 0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_UNLINK, 10'd1023, 10'd1023, 0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_UNLINK, 10'd1023, 10'd1023, 0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_PUSH,   10'd1,    10'd0,    0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_UNLINK, 10'd1,    10'd1023, 0,    '{10'd0,    10'd0,    10'd0}},
        '{CMD_HEAD,   10'd0,    10'd0,    0,    '{10'd0,    10'd0,    10'd0}}
    };

    degree_bucket_list_engine_top #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_column      (s_column),
        .s_degree      (s_degree),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bucket_head (m_bucket_head),
        .m_next_column (m_next_column),
        .m_prev_column (m_prev_column)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic bit column_in_range(col_t c);
        return c >= 1 && c <= NUM_COLUMNS;
    endfunction

    // applies one command to the store model and returns the view after it
    function automatic column_view_t apply_command(cmd_t cmd, col_t c, col_t d);
        column_view_t v;
        col_t         old_head;
        col_t         p;
        col_t         n;
        bit           col_ok;
        bit           deg_ok;
        col_ok = column_in_range(c);
        deg_ok = int'(d) < NUM_BUCKETS;
        if (col_ok && deg_ok) begin
            if (cmd == CMD_PUSH) begin
                old_head = head_mem[d];
                prev_mem[c] = '0;
                next_mem[c] = old_head;
                if (column_in_range(old_head))
                    prev_mem[old_head] = c;
                head_mem[d] = c;
            end else if (cmd == CMD_UNLINK) begin
                // the removed column keeps its stale links
                p = prev_mem[c];
                n = next_mem[c];
                if (p == '0)
                    head_mem[d] = n;
                else if (column_in_range(p))
                    next_mem[p] = n;
                if (column_in_range(n))
                    prev_mem[n] = p;
            end
        end
        v.head = deg_ok ? head_mem[d] : '0;
        v.nxt  = col_ok ? next_mem[c] : '0;
        v.prv  = col_ok ? prev_mem[c] : '0;
        return v;
    endfunction

    // any column ever pushed, so its links are known; 0 when none yet
    function automatic col_t pick_known_col();
        if (known_cols.size() == 0)
            return '0;
        return known_cols[$urandom_range(known_cols.size() - 1)];
    endfunction

    task automatic send_item(input cmd_t cmd, input col_t col, input col_t deg,
                             input bit typed, input column_view_t typed_view);
        column_view_t v;
        int           phase;
        if ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_column <= col;
        s_degree <= deg;
        do @(posedge aclk); while (!s_ready);
        v = apply_command(cmd, col, deg);
        expected_views.push_back(typed ? typed_view : v);
        if (cmd == CMD_PUSH && col != '0 && !col_known[col]) begin
            col_known[col] = 1'b1;
            known_cols.push_back(col);
        end
        items_sent++;
        phase = items_sent * 3 / total_items;
        if (phase == 1) begin
            src_gap_pct = 54;
            snk_gap_pct = 13;
        end else if (phase >= 2) begin
            src_gap_pct = 0;
            snk_gap_pct = 0;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_gap_pct);
    end

    always @(posedge aclk) begin : check_results
        column_view_t exp_v;
        if (aresetn && m_valid && m_ready) begin
            if (expected_views.size() == 0) begin
                $error("unexpected result: bucket_head %0d next_column %0d prev_column %0d",
                       m_bucket_head, m_next_column, m_prev_column);
                fail_count++;
            end else begin
                exp_v = expected_views.pop_front();
                if (m_bucket_head !== exp_v.head) begin
                    $error("bucket_head: expected %0d, got %0d", exp_v.head, m_bucket_head);
                    fail_count++;
                end
                if (m_next_column !== exp_v.nxt) begin
                    $error("next_column: expected %0d, got %0d", exp_v.nxt, m_next_column);
                    fail_count++;
                end
                if (m_prev_column !== exp_v.prv) begin
                    $error("prev_column: expected %0d, got %0d", exp_v.prv, m_prev_column);
                    fail_count++;
                end
            end
        end
    end

    // covers the head sweep after reset as well as stalls
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("degree_bucket_list_engine_top_tb failed");
            $finish;
        end
    end

    initial begin
        int   r;
        int   idx;
        int   tries;
        int   steps;
        col_t c;
        col_t d;
        for (int i = 0; i < NUM_BUCKETS; i++)
            head_mem[i] = '0;
        for (int i = 0; i <= NUM_COLUMNS; i++) begin
            next_mem[i]   = '0;
            prev_mem[i]   = '0;
            col_known[i]  = 1'b0;
            member_deg[i] = -1;
        end
        total_items = RANDOM_ITEMS + $size(directed_rows);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].column, directed_rows[i].degree,
                      directed_rows[i].typed, directed_rows[i].view);
        // table leaves 1 in bucket 0 and stale links elsewhere
        member_deg[1] = 0;
        listed_cols.push_back(10'd1);

        while (items_sent < total_items) begin
            r = $urandom_range(99);
            if (r < 40 || (r < 65 && listed_cols.size() == 0)) begin
                // push a column, tried up to 8 times for one not listed yet, into a mostly small degree
                tries = 0;
                do begin
                    c = col_t'($urandom_range(NUM_COLUMNS, 1));
                    tries++;
                end while (member_deg[c] >= 0 && tries < 8);
                d = ($urandom_range(3) == 0) ? col_t'($urandom_range(NUM_BUCKETS - 1))
                                             : col_t'($urandom_range(7));
                if (member_deg[c] < 0)
                    listed_cols.push_back(c);
                member_deg[c] = int'(d);
                send_item(CMD_PUSH, c, d, 0, '0);
            end else if (r < 65) begin
                idx = $urandom_range(listed_cols.size() - 1);
                c = listed_cols[idx];
                d = col_t'(member_deg[c]);
                listed_cols.delete(idx);
                member_deg[c] = -1;
                send_item(CMD_UNLINK, c, d, 0, '0);
            end else if (r < 76) begin
                // walk one bucket from its head along the successor links
                if (listed_cols.size() != 0 && $urandom_range(3) != 0)
                    d = col_t'(member_deg[listed_cols[$urandom_range(listed_cols.size() - 1)]]);
                else
                    d = col_t'($urandom_range(7));
                send_item(CMD_HEAD, pick_known_col(), d, 0, '0);
                c = head_mem[d];
                steps = 0;
                while (c != '0 && steps < WALK_MAX) begin
                    send_item(CMD_LINKS, c, d, 0, '0);
                    c = next_mem[c];
                    steps++;
                end
            end else if (r < 86) begin
                send_item(CMD_LINKS, pick_known_col(), col_t'($urandom_range(NUM_BUCKETS - 1)),
                          0, '0);
            end else if (r < 93) begin
                send_item(CMD_HEAD, pick_known_col(), col_t'($urandom_range(NUM_BUCKETS - 1)),
                          0, '0);
            end else begin
                // broken sequences: null column, repeat push, wrong bucket, second unlink
                case ($urandom_range(3))
                    0: send_item(cmd_t'($urandom_range(3)), '0,
                                 col_t'($urandom_range(NUM_BUCKETS - 1)), 0, '0);
                    1: begin
                        if (listed_cols.size() != 0) begin
                            c = listed_cols[$urandom_range(listed_cols.size() - 1)];
                            d = col_t'($urandom_range(7));
                            member_deg[c] = int'(d);
                            send_item(CMD_PUSH, c, d, 0, '0);
                        end
                    end
                    2: begin
                        if (listed_cols.size() != 0) begin
                            idx = $urandom_range(listed_cols.size() - 1);
                            c = listed_cols[idx];
                            d = col_t'((member_deg[c] + 1) % 8);
                            listed_cols.delete(idx);
                            member_deg[c] = -1;
                            send_item(CMD_UNLINK, c, d, 0, '0);
                        end
                    end
                    default: begin
                        tries = 0;
                        do begin
                            c = pick_known_col();
                            tries++;
                        end while (c != '0 && member_deg[c] >= 0 && tries < 8);
                        if (c != '0 && member_deg[c] < 0)
                            send_item(CMD_UNLINK, c, col_t'($urandom_range(7)), 0, '0);
                    end
                endcase
            end
        end
        s_valid <= 1'b0;

        while (expected_views.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("degree_bucket_list_engine_top_tb passed");
        else
            $display("degree_bucket_list_engine_top_tb failed");
        $finish;
    end

endmodule
